/* rtl/sha1s_pkg.sv */
// ----------------------------------------------------------------------------
// sha1s_pkg
// Shared types, constants and helpers for the SHA-1 byte-stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1s_pkg;

  // Geometry of the hash.
  localparam int NUM_CHAIN   = 5;
  localparam int NUM_BLOCK   = 16;
  localparam int BLOCK_BYTES = 64;
  localparam int LEN_POS     = 56;
  localparam int ROUNDS      = 80;
  localparam int GRP_LEN     = 20;

  localparam int CNT_W  = $clog2(BLOCK_BYTES);
  localparam int RND_W  = $clog2(ROUNDS);
  localparam int OCNT_W = $clog2(NUM_CHAIN + 1);

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Initial chaining value.
  localparam logic [31:0] H_INIT [NUM_CHAIN] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZ,
    ST_PADLEN,
    ST_ROUND,
    ST_ADD,
    ST_DONE
  } state_t;

  // Source of the byte shifted into the block buffer.
  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_80,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  // Round group: selects the boolean function and the round constant.
  typedef enum logic [1:0] {
    GRP_CH,
    GRP_PAR1,
    GRP_MAJ,
    GRP_PAR2
  } rgrp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      push;
    byte_sel_t byte_sel;
    logic      len_inc;
    logic      start;
    logic      round;
    rgrp_t     grp;
    logic      add;
    logic      finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_last;
    logic cnt_pre_len;
    logic out_busy;
  } sts_t;

  // Round constant for a group.
  function automatic logic [31:0] round_k(rgrp_t grp);
    logic [31:0] k;
    unique case (grp)
      GRP_CH:   k = 32'h5a827999;
      GRP_PAR1: k = 32'h6ed9eba1;
      GRP_MAJ:  k = 32'h8f1bbcdc;
      GRP_PAR2: k = 32'hca62c1d6;
      default:  k = 32'h5a827999;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* rtl/sha1s_if.sv */
// ----------------------------------------------------------------------------
// sha1s_if
// Valid/ready channel interfaces for the input items and the digest words.
// ----------------------------------------------------------------------------
`default_nettype none

// Input channel: one append or finish item per transaction.
interface sha1s_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// Result channel: one digest word per transaction.
interface sha1s_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        last_word;

  modport source (output valid, output digest_word, output last_word, input ready);
  modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface

`default_nettype wire

/* rtl/sha1_stream_hash.sv */
// ----------------------------------------------------------------------------
// sha1_stream_hash
// SHA-1 over a byte stream: append items add message bytes, a finish item
// pads the message and returns the 160-bit digest as five 32-bit words.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Transaction payload
//   --------+-----------+---------------------------------------------
//   in_ch   | sink      | kind (0 append, 1 finish), data_byte[7:0]
//   out_ch  | source    | digest_word[31:0] (H0 first), last_word
//
// An append byte is shifted into the block buffer; the 64th byte of a block
// also starts the 80 rounds of the single round unit and the chain update.
// A finish is followed by 9 to 72 padding bytes, one or two blocks of rounds
// and the load of the output buffer, which then drains at one word a cycle
// while out_ready is high.
// Reset is synchronous and active low and needs no clearing pass.
// New items are accepted while the previous digest still drains; a finish
// waits before its load until the output buffer is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_stream_hash import sha1s_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  sha1s_in_if.sink    in_ch,
  sha1s_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  sha1s_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hash datapath and output buffer.
  sha1s_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_ch.data_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_digest_word (out_ch.digest_word),
    .out_last_word   (out_ch.last_word)
  );

endmodule

`default_nettype wire

/* rtl/sha1s_ctrl.sv */
// ----------------------------------------------------------------------------
// sha1s_ctrl
// Sequencer: accepts items, drives padding, runs the 80 rounds and the chain
// update, and hands the finished digest to the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1s_ctrl import sha1s_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t            state_r, state_nxt;
  state_t            ret_r, ret_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;

  // State, return state and round counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    rnd_nxt      = rnd_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.byte_sel = SEL_DATA;
    cmd.grp      = GRP_CH;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_kind) begin
            cmd.push    = 1'b1;
            cmd.len_inc = 1'b1;
            if (sts.cnt_last) begin
              cmd.start = 1'b1;
              ret_nxt   = ST_IDLE;
              rnd_nxt   = '0;
              state_nxt = ST_ROUND;
            end
          end else begin
            state_nxt = ST_PAD80;
          end
        end
      end

      ST_PAD80: begin
        cmd.push     = 1'b1;
        cmd.byte_sel = SEL_80;
        if (sts.cnt_last) begin
          cmd.start = 1'b1;
          ret_nxt   = ST_PADZ;
          rnd_nxt   = '0;
          state_nxt = ST_ROUND;
        end else if (sts.cnt_pre_len) begin
          state_nxt = ST_PADLEN;
        end else begin
          state_nxt = ST_PADZ;
        end
      end

      ST_PADZ: begin
        cmd.push     = 1'b1;
        cmd.byte_sel = SEL_ZERO;
        if (sts.cnt_last) begin
          cmd.start = 1'b1;
          ret_nxt   = ST_PADZ;
          rnd_nxt   = '0;
          state_nxt = ST_ROUND;
        end else if (sts.cnt_pre_len) begin
          state_nxt = ST_PADLEN;
        end
      end

      // The length field always fills the block up to its last byte.
      ST_PADLEN: begin
        cmd.push     = 1'b1;
        cmd.byte_sel = SEL_LEN;
        if (sts.cnt_last) begin
          cmd.start = 1'b1;
          ret_nxt   = ST_DONE;
          rnd_nxt   = '0;
          state_nxt = ST_ROUND;
        end
      end

      ST_ROUND: begin
        cmd.round = 1'b1;
        if (rnd_r < RND_W'(GRP_LEN)) begin
          cmd.grp = GRP_CH;
        end else if (rnd_r < RND_W'(2 * GRP_LEN)) begin
          cmd.grp = GRP_PAR1;
        end else if (rnd_r < RND_W'(3 * GRP_LEN)) begin
          cmd.grp = GRP_MAJ;
        end else begin
          cmd.grp = GRP_PAR2;
        end
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == RND_W'(ROUNDS - 1)) begin
          state_nxt = ST_ADD;
        end
      end

      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ret_r;
      end

      // Wait until the previous digest has fully drained.
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/sha1s_dp.sv */
// ----------------------------------------------------------------------------
// sha1s_dp
// Datapath: block buffer that doubles as the message schedule window, working
// registers, chaining words, bit-length counter and the digest output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1s_dp import sha1s_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_data_byte,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic        out_last_word
);

  logic [31:0]       blk_r [NUM_BLOCK];
  logic [31:0]       blk_nxt [NUM_BLOCK];
  logic [31:0]       wk_r [NUM_CHAIN];
  logic [31:0]       h_r [NUM_CHAIN];
  logic [31:0]       ob_r [NUM_CHAIN];
  logic [63:0]       len_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [OCNT_W-1:0] ocnt_r;

  logic [7:0]  push_val;
  logic [31:0] w_new;
  logic [31:0] f_val;
  logic [31:0] t_val;
  logic        out_fire;

  // Byte to shift in; the length goes out most significant byte first.
  always_comb begin
    unique case (cmd.byte_sel)
      SEL_DATA: push_val = in_data_byte;
      SEL_80:   push_val = PAD_BYTE;
      SEL_ZERO: push_val = 8'h00;
      SEL_LEN:  push_val = len_r[{~cnt_r[2:0], 3'b000} +: 8];
      default:  push_val = 8'h00;
    endcase
  end

  // Next schedule word from the fixed taps of the sixteen-word window.
  assign w_new = {(blk_r[13][30:0] ^ blk_r[8][30:0] ^ blk_r[2][30:0] ^ blk_r[0][30:0]),
                  (blk_r[13][31] ^ blk_r[8][31] ^ blk_r[2][31] ^ blk_r[0][31])};

  // Block buffer: byte shift while loading, word shift during rounds.
  always_comb begin
    for (int i = 0; i < NUM_BLOCK; i++) begin
      blk_nxt[i] = blk_r[i];
    end
    if (cmd.push) begin
      for (int i = 0; i < NUM_BLOCK - 1; i++) begin
        blk_nxt[i] = {blk_r[i][23:0], blk_r[i + 1][31:24]};
      end
      blk_nxt[NUM_BLOCK - 1] = {blk_r[NUM_BLOCK - 1][23:0], push_val};
    end else if (cmd.round) begin
      for (int i = 0; i < NUM_BLOCK - 1; i++) begin
        blk_nxt[i] = blk_r[i + 1];
      end
      blk_nxt[NUM_BLOCK - 1] = w_new;
    end
  end

  // Round function of the current group.
  always_comb begin
    case (cmd.grp) inside
      GRP_CH:             f_val = ((wk_r[2] ^ wk_r[3]) & wk_r[1]) ^ wk_r[3];
      GRP_MAJ:            f_val = (wk_r[1] & wk_r[2]) | (wk_r[3] & (wk_r[1] | wk_r[2]));
      GRP_PAR1, GRP_PAR2: f_val = wk_r[1] ^ wk_r[2] ^ wk_r[3];
      default:            f_val = wk_r[1] ^ wk_r[2] ^ wk_r[3];
    endcase
  end

  assign t_val = {wk_r[0][26:0], wk_r[0][31:27]} + f_val + wk_r[4] + blk_r[0]
                 + round_k(cmd.grp);

  assign out_fire = out_valid && out_ready;

  // Block buffer, working registers and output words carry no reset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_BLOCK; i++) begin
      blk_r[i] <= blk_nxt[i];
    end
    if (cmd.start) begin
      for (int i = 0; i < NUM_CHAIN; i++) begin
        wk_r[i] <= h_r[i];
      end
    end else if (cmd.round) begin
      wk_r[0] <= t_val;
      wk_r[1] <= wk_r[0];
      wk_r[2] <= {wk_r[1][1:0], wk_r[1][31:2]};
      wk_r[3] <= wk_r[2];
      wk_r[4] <= wk_r[3];
    end
    if (cmd.finish) begin
      for (int i = 0; i < NUM_CHAIN; i++) begin
        ob_r[i] <= h_r[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < NUM_CHAIN - 1; i++) begin
        ob_r[i] <= ob_r[i + 1];
      end
    end
  end

  // Chaining words, counters and output occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHAIN; i++) begin
        h_r[i] <= H_INIT[i];
      end
      len_r  <= '0;
      cnt_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (cmd.push) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.len_inc) begin
        len_r <= len_r + 64'd8;
      end
      if (cmd.add) begin
        for (int i = 0; i < NUM_CHAIN; i++) begin
          h_r[i] <= h_r[i] + wk_r[i];
        end
      end
      if (cmd.finish) begin
        for (int i = 0; i < NUM_CHAIN; i++) begin
          h_r[i] <= H_INIT[i];
        end
        len_r  <= '0;
        cnt_r  <= '0;
        ocnt_r <= OCNT_W'(NUM_CHAIN);
      end else if (out_fire) begin
        ocnt_r <= ocnt_r - 1'b1;
      end
    end
  end

  // Status and output channel.
  assign sts.cnt_last    = (cnt_r == CNT_W'(BLOCK_BYTES - 1));
  assign sts.cnt_pre_len = (cnt_r == CNT_W'(LEN_POS - 1));
  assign sts.out_busy    = (ocnt_r != '0);

  assign out_valid       = (ocnt_r != '0);
  assign out_digest_word = ob_r[0];
  assign out_last_word   = (ocnt_r == OCNT_W'(1));

endmodule

`default_nettype wire

/* rtl/sha1s_chk.sv */
// ----------------------------------------------------------------------------
// sha1s_chk
// Port-level checks for the SHA-1 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1s_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        in_kind,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_digest_word,
  input wire        out_last_word
);

  // An append transaction never starts a digest.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_kind && !out_valid) |=> !out_valid)
    else $error("digest started by an append transaction");

  // A finish transaction is followed by padding, so input stalls.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind) |=> !in_ready)
    else $error("input accepted right after a finish transaction");

  // The first word of a digest is never the last one.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !out_last_word)
    else $error("digest started with the last word");

  // A stalled digest word holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_digest_word) && $stable(out_last_word)))
    else $error("stalled digest word changed");

endmodule

bind sha1_stream_hash sha1s_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_kind         (in_ch.kind),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_digest_word (out_ch.digest_word),
  .out_last_word   (out_ch.last_word)
);

`default_nettype wire

/* tb/sha1_stream_hash_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha1_stream_hash_tb
// Drives byte streams and finish commands into the SHA-1 hasher, predicts
// every digest word with a behavioral SHA-1 and checks the five-word
// responses in order. It covers random valid/ready gaps on both channels
// and one long output stall that backs up the input.
// ----------------------------------------------------------------------------

module sha1_stream_hash_tb;
  import sha1s_pkg::*;

  // Item kinds on the input channel.
  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 1000;

  localparam logic [31:0] ROUND_CONST [4] = '{
    32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
  };

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } hash_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } digest_beat_t;

  logic clk;
  logic rst_n;

  sha1s_in_if  in_ch ();
  sha1s_out_if out_ch ();

  sha1_stream_hash dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hash_item_t   item_q[$];
  digest_beat_t pending_digest_words[$];

  int  n_total;
  int  n_accepted;
  int  n_errors;
  int  cycle;
  int  hold_left;
  bit  hold_done;
  bit  in_fire;

  // Model state of the hasher.
  logic [31:0] chain_state [NUM_CHAIN];
  logic [31:0] block_buf [NUM_BLOCK];
  logic [5:0]  fill_count;
  logic [63:0] bit_count;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycle++;
    if (cycle > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle);
      $display("sha1_stream_hash_tb failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 20) $display("ERROR cycle %0d: %s", cycle, msg);
  endtask

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic clear_hash_state();
    for (int i = 0; i < NUM_CHAIN; i++) chain_state[i] = H_INIT[i];
    for (int i = 0; i < NUM_BLOCK; i++) block_buf[i] = '0;
    fill_count = '0;
    bit_count = '0;
  endtask

  // Fold the full block buffer into the chaining words.
  task automatic compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, t;
    for (int i = 0; i < 16; i++) w[i] = block_buf[i];
    for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain_state[0];
    b = chain_state[1];
    c = chain_state[2];
    d = chain_state[3];
    e = chain_state[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) f = ((c ^ d) & b) ^ d;
      else if (i < 40) f = b ^ c ^ d;
      else if (i < 60) f = (b & c) | (d & (b | c));
      else f = b ^ c ^ d;
      t = rotl(a, 5) + f + e + w[i] + ROUND_CONST[i / 20];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_state[0] += a;
    chain_state[1] += b;
    chain_state[2] += c;
    chain_state[3] += d;
    chain_state[4] += e;
  endtask

  task automatic absorb_byte(input logic [7:0] value);
    logic [3:0] idx;
    idx = fill_count[5:2];
    block_buf[idx] = {block_buf[idx][23:0], value};
    fill_count = fill_count + 6'd1;
    if (fill_count == '0) compress_block();
  endtask

  // Apply one accepted item to the model; a finish queues five digest words.
  task automatic predict_digest(input hash_item_t it);
    logic [63:0] msg_bits;
    if (it.kind == KIND_APPEND) begin
      absorb_byte(it.data_byte);
      bit_count += 64'd8;
    end else begin
      msg_bits = bit_count;
      absorb_byte(PAD_BYTE);
      while (fill_count != LEN_POS) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(msg_bits[63 - 8 * i -: 8]);
      for (int i = 0; i < NUM_CHAIN; i++)
        pending_digest_words.push_back('{chain_state[i], i == NUM_CHAIN - 1});
      clear_hash_state();
    end
  endtask

  task automatic add_item(input logic kind, input logic [7:0] value);
    item_q.push_back('{kind, value});
  endtask

  // A message of random bytes followed by a finish with a random stray byte.
  task automatic add_message(input int len);
    for (int i = 0; i < len; i++) add_item(KIND_APPEND, 8'($urandom_range(255)));
    add_item(KIND_FINISH, 8'($urandom_range(255)));
  endtask

  task automatic build_stimulus();
    int edge_lens [9];
    int len;
    edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
    // Empty message, with the data byte set to be ignored.
    add_item(KIND_FINISH, 8'hff);
    // "abc"
    add_item(KIND_APPEND, 8'h61);
    add_item(KIND_APPEND, 8'h62);
    add_item(KIND_APPEND, 8'h63);
    add_item(KIND_FINISH, 8'h00);
    // Byte extremes.
    add_item(KIND_APPEND, 8'h00);
    add_item(KIND_APPEND, 8'hff);
    add_item(KIND_FINISH, 8'ha5);
    add_item(KIND_APPEND, 8'h80);
    add_item(KIND_FINISH, 8'h5a);
    add_item(KIND_FINISH, 8'h00);
    // Random messages, a fair share at the padding and block boundaries.
    while (item_q.size() < RANDOM_ITEMS + 11) begin
      case ($urandom_range(9))
        0, 1: len = edge_lens[$urandom_range(8)];
        2:    len = $urandom_range(200, 66);
        default: len = $urandom_range(24);
      endcase
      add_message(len);
    end
  endtask

  function automatic int sender_idle_pct();
    if (n_accepted < n_total / 3) return 20;
    else if (n_accepted < 2 * n_total / 3) return 84;
    else return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (n_accepted < n_total / 3) return 84;
    else if (n_accepted < 2 * n_total / 3) return 20;
    else return 0;
  endfunction

  // Input acceptance: predict each transaction as it is taken.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_digest('{in_ch.kind, in_ch.data_byte});
      n_accepted++;
      in_fire = 1'b1;
    end
  end

  // Input driver: present the next item once the current one is taken.
  always @(negedge clk) begin
    hash_item_t it;
    if (rst_n && (in_fire || !in_ch.valid)) begin
      if (item_q.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
        it = item_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= it.kind;
        in_ch.data_byte <= it.data_byte;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    in_fire = 1'b0;
  end

  // Long output stall once the unthrottled phase is under way.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (!hold_done && n_accepted >= 2 * n_total / 3 + 20) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
  end

  // Output ready with random backpressure.
  always @(negedge clk) begin
    out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct());
  end

  // Output monitor: compare each digest transaction with the oldest expectation.
  always @(posedge clk) begin
    digest_beat_t exp_beat;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_digest_words.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %08h", out_ch.digest_word));
      end else begin
        exp_beat = pending_digest_words.pop_front();
        if (out_ch.digest_word !== exp_beat.digest_word)
          report_mismatch($sformatf("digest_word %08h, expected %08h",
                                    out_ch.digest_word, exp_beat.digest_word));
        if (out_ch.last_word !== exp_beat.last_word)
          report_mismatch($sformatf("last_word %0b, expected %0b",
                                    out_ch.last_word, exp_beat.last_word));
      end
    end
  end

  // Reset, stimulus and end of test.
  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_APPEND;
    in_ch.data_byte = 8'h00;
    out_ch.ready    = 1'b0;
    n_accepted      = 0;
    n_errors        = 0;
    cycle           = 0;
    hold_left       = 0;
    hold_done       = 1'b0;
    in_fire         = 1'b0;
    clear_hash_state();
    build_stimulus();
    n_total = item_q.size();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    while (n_accepted < n_total) @(posedge clk);
    while (pending_digest_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("sha1_stream_hash_tb passed");
    end else begin
      $display("sha1_stream_hash_tb failed");
    end
    $finish;
  end

endmodule
